// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checkers of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: design/necirtx_pkg.sv
// ----------------------------------------------------------------------------
// NEC IR transmitter package
// Transaction types, register indexes and frame constants.
// ----------------------------------------------------------------------------
package necirtx_pkg;

  localparam int unsigned FrameBits   = 32;
  localparam int unsigned BitsLeftW   = $clog2(FrameBits + 1);
  localparam int unsigned UnitW       = 5;
  localparam int unsigned CfgIndexW   = 2;
  localparam int unsigned CfgDataW    = 8;

  localparam logic [CfgIndexW-1:0] RegDeviceAddress    = 2'd0;
  localparam logic [CfgIndexW-1:0] RegLeaderMarkUnits  = 2'd1;
  localparam logic [CfgIndexW-1:0] RegLeaderSpaceUnits = 2'd2;
  localparam logic [CfgIndexW-1:0] RegOneSpaceUnits    = 2'd3;

  localparam logic [7:0]       DeviceAddressReset    = 8'd0;
  localparam logic [UnitW-1:0] LeaderMarkReset       = 5'd16;
  localparam logic [UnitW-1:0] LeaderSpaceReset      = 5'd8;
  localparam logic [2:0]       OneSpaceReset         = 3'd3;
  localparam logic [UnitW-1:0] MarkDuration          = 5'd1;

  localparam logic KindTick    = 1'b0;
  localparam logic KindRequest = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] command;
  } nec_in_t;

  typedef struct packed {
    logic carrier_on;
    logic busy_res;
    logic frame_done;
    logic request_dropped;
  } nec_out_t;

  function automatic logic [FrameBits-1:0] build_frame(input logic [7:0] addr,
                                                        input logic [7:0] cmd);
    logic [31:0] frame;
    frame = {~cmd, cmd, ~addr, addr};
    return FrameBits'(frame);
  endfunction

endpackage

// File: design/nec_ir_frame_transmitter_unit.sv
// ----------------------------------------------------------------------------
// NEC IR frame transmitter
// Builds the NEC frame on a send request while idle, drops one while busy,
// and reports the carrier envelope for each time-unit tick transaction.
// ----------------------------------------------------------------------------
// The result of an accepted transaction is valid in the following cycle.
// Throughput: one transaction per cycle while not stalled; the frame state
// and the result register are updated in the same cycle it is accepted.
// Reset: asynchronous, active low; clears the frame state to idle, loads the
// register defaults and clears the result valid flag.
module nec_ir_frame_transmitter_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [necirtx_pkg::CfgIndexW-1:0]     cfg_index_i,
  input  logic [necirtx_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  necirtx_pkg::nec_in_t                  in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output necirtx_pkg::nec_out_t                 out_data_o
);
  import necirtx_pkg::*;

  typedef enum logic [2:0] {
    PhIdle,
    PhLeadMark,
    PhLeadSpace,
    PhBitMark,
    PhBitSpace,
    PhStopMark
  } phase_e;

  logic [7:0]           dev_addr_q;
  logic [UnitW-1:0]     lead_mark_q;
  logic [UnitW-1:0]     lead_space_q;
  logic [2:0]           one_space_q;

  phase_e               phase_q, phase_d;
  logic [UnitW-1:0]     unit_q, unit_d;
  logic [FrameBits-1:0] shift_q, shift_d;
  logic [BitsLeftW-1:0] bits_q, bits_d;
  logic [BitsLeftW-1:0] bits_dec;

  logic                 out_valid_q;
  nec_out_t             out_q, res_d;
  logic                 accept;
  logic [UnitW-1:0]     len;
  logic [UnitW-1:0]     unit_inc;
  logic                 phase_end;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    unique case (phase_q)
      PhLeadMark:  len = lead_mark_q;
      PhLeadSpace: len = lead_space_q;
      PhBitSpace:  len = shift_q[0] ? UnitW'(one_space_q) : MarkDuration;
      default:     len = MarkDuration;
    endcase
  end

  assign unit_inc  = unit_q + UnitW'(1);
  assign phase_end = (unit_inc >= len) || (unit_inc == '0);
  assign bits_dec  = (bits_q != '0) ? bits_q - BitsLeftW'(1) : bits_q;

  always_comb begin
    phase_d = phase_q;
    unit_d  = unit_q;
    shift_d = shift_q;
    bits_d  = bits_q;
    res_d   = '0;
    if (in_data_i.kind == KindRequest) begin
      res_d.busy_res = 1'b1;
      if (phase_q == PhIdle) begin
        shift_d = build_frame(dev_addr_q, in_data_i.command);
        bits_d  = BitsLeftW'(FrameBits);
        unit_d  = '0;
        phase_d = PhLeadMark;
      end else begin
        res_d.request_dropped = 1'b1;
      end
    end else if (phase_q != PhIdle) begin
      res_d.busy_res   = 1'b1;
      res_d.carrier_on = (phase_q == PhLeadMark) || (phase_q == PhBitMark) ||
                         (phase_q == PhStopMark);
      unit_d = unit_inc;
      if (phase_end) begin
        unit_d = '0;
        unique case (phase_q)
          PhLeadMark:  phase_d = PhLeadSpace;
          PhLeadSpace: phase_d = (bits_q == '0) ? PhStopMark : PhBitMark;
          PhBitMark:   phase_d = PhBitSpace;
          PhBitSpace: begin
            shift_d = shift_q >> 1;
            bits_d  = bits_dec;
            phase_d = (bits_dec == '0) ? PhStopMark : PhBitMark;
          end
          default: begin
            phase_d          = PhIdle;
            shift_d          = '0;
            bits_d           = '0;
            res_d.frame_done = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q   <= DeviceAddressReset;
      lead_mark_q  <= LeaderMarkReset;
      lead_space_q <= LeaderSpaceReset;
      one_space_q  <= OneSpaceReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegDeviceAddress:    dev_addr_q   <= cfg_data_i;
        RegLeaderMarkUnits:  lead_mark_q  <= cfg_data_i[UnitW-1:0];
        RegLeaderSpaceUnits: lead_space_q <= cfg_data_i[UnitW-1:0];
        RegOneSpaceUnits:    one_space_q  <= cfg_data_i[2:0];
        default:             dev_addr_q   <= dev_addr_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      unit_q      <= '0;
      shift_q     <= '0;
      bits_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q     <= phase_d;
        unit_q      <= unit_d;
        shift_q     <= shift_d;
        bits_q      <= bits_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res_d;
    end
  end

endmodule

// File: design/necirtx_checker.sv
// ----------------------------------------------------------------------------
// NEC IR transmitter checker
// Port-level assertions on the transmitter, attached by a bind statement.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module necirtx_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input necirtx_pkg::nec_out_t  out_data_o
);
  import necirtx_pkg::*;

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
               out_valid_o && $stable(out_data_o), "stalled result changed")

  `ASSERT_SAME(a_stall_cause, clk_i, rst_ni, in_stall_o,
               out_valid_o && out_stall_i, "input stalled without a held result")

  `ASSERT_NEXT(a_accept_result, clk_i, rst_ni, in_valid_i && !in_stall_o,
               out_valid_o, "accepted transaction produced no result")

  `ASSERT_SAME(a_done_shape, clk_i, rst_ni, out_valid_o && out_data_o.frame_done,
               out_data_o.busy_res && out_data_o.carrier_on &&
               !out_data_o.request_dropped, "frame end without stop mark")

  `ASSERT_SAME(a_drop_shape, clk_i, rst_ni,
               out_valid_o && out_data_o.request_dropped,
               out_data_o.busy_res && !out_data_o.carrier_on &&
               !out_data_o.frame_done, "dropped request with tick fields set")

endmodule

bind nec_ir_frame_transmitter_unit necirtx_checker u_necirtx_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NEC IR frame transmitter testbench
// Drives tick and send-request transactions with random gaps on both sides
// and checks every result against a cycle-free model of the frame sequencer.
// ----------------------------------------------------------------------------
module testbench;
  import necirtx_pkg::*;

  localparam int unsigned StallLimit = 2000;

  typedef enum logic [2:0] {
    TxIdle,
    TxLeadMark,
    TxLeadSpace,
    TxBitMark,
    TxBitSpace,
    TxStopMark
  } tx_phase_e;

  class envelope_scoreboard;
    logic [7:0]           dev_addr;
    logic [UnitW-1:0]     lead_mark;
    logic [UnitW-1:0]     lead_space;
    logic [2:0]           one_space;
    tx_phase_e            phase;
    logic [UnitW-1:0]     units;
    logic [FrameBits-1:0] frame_bits;
    logic [BitsLeftW-1:0] bits_left;
    nec_out_t             expected_envelopes[$];
    int unsigned          errors;
    int unsigned          results_seen;

    function new();
      dev_addr     = DeviceAddressReset;
      lead_mark    = LeaderMarkReset;
      lead_space   = LeaderSpaceReset;
      one_space    = OneSpaceReset;
      phase        = TxIdle;
      units        = '0;
      frame_bits   = '0;
      bits_left    = '0;
      errors       = 0;
      results_seen = 0;
    endfunction

    function void set_register(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] value);
      case (idx)
        RegDeviceAddress:    dev_addr   = value[7:0];
        RegLeaderMarkUnits:  lead_mark  = value[UnitW-1:0];
        RegLeaderSpaceUnits: lead_space = value[UnitW-1:0];
        default:             one_space  = value[2:0];
      endcase
    endfunction

    function bit busy();
      return phase != TxIdle;
    endfunction

    function int unsigned pending();
      return expected_envelopes.size();
    endfunction

    function nec_out_t next_envelope(nec_in_t item);
      nec_out_t         env;
      logic [UnitW-1:0] span;
      env = '0;
      if (item.kind == KindRequest) begin
        if (phase == TxIdle) begin
          frame_bits = {~item.command, item.command, ~dev_addr, dev_addr};
          bits_left  = BitsLeftW'(FrameBits);
          units      = '0;
          phase      = TxLeadMark;
        end else begin
          env.request_dropped = 1'b1;
        end
        env.busy_res = 1'b1;
      end else if (phase != TxIdle) begin
        case (phase)
          TxLeadMark:  span = lead_mark;
          TxLeadSpace: span = lead_space;
          TxBitSpace:  span = frame_bits[0] ? UnitW'(one_space) : MarkDuration;
          default:     span = MarkDuration;
        endcase
        env.busy_res   = 1'b1;
        env.carrier_on = (phase == TxLeadMark) || (phase == TxBitMark) ||
                         (phase == TxStopMark);
        units = units + UnitW'(1);
        if (units >= span || units == '0) begin
          units = '0;
          case (phase)
            TxLeadMark: begin
              phase = TxLeadSpace;
            end
            TxLeadSpace: begin
              if (bits_left == '0) phase = TxStopMark;
              else phase = TxBitMark;
            end
            TxBitMark: begin
              phase = TxBitSpace;
            end
            TxBitSpace: begin
              frame_bits = frame_bits >> 1;
              if (bits_left != '0) bits_left = bits_left - BitsLeftW'(1);
              if (bits_left == '0) phase = TxStopMark;
              else phase = TxBitMark;
            end
            default: begin
              phase            = TxIdle;
              frame_bits       = '0;
              bits_left        = '0;
              env.frame_done   = 1'b1;
            end
          endcase
        end
      end
      return env;
    endfunction

    function void record_item(nec_in_t item);
      expected_envelopes.push_back(next_envelope(item));
    endfunction

    task report(string what);
      errors++;
      $display("%0t ERROR result %0d: %s", $time, results_seen, what);
    endtask

    task check_field(string name, logic got, logic want);
      if (got !== want) report($sformatf("%s is %b, expected %b", name, got, want));
    endtask

    task compare_envelope(nec_out_t got);
      nec_out_t want;
      results_seen++;
      if (expected_envelopes.size() == 0) begin
        report($sformatf("unexpected transaction %b", got));
        return;
      end
      want = expected_envelopes.pop_front();
      check_field("carrier_on", got.carrier_on, want.carrier_on);
      check_field("busy_res", got.busy_res, want.busy_res);
      check_field("frame_done", got.frame_done, want.frame_done);
      check_field("request_dropped", got.request_dropped, want.request_dropped);
    endtask
  endclass

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CfgIndexW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  nec_in_t              in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  nec_out_t             out_data_o;

  envelope_scoreboard sb;
  bit                 quiet;
  int unsigned        items_sent;
  int unsigned        idle_cycles;

  nec_ir_frame_transmitter_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned pick_gap();
    return quiet ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic nec_in_t make_item(logic kind, logic [7:0] cmd);
    nec_in_t item;
    item.kind    = kind;
    item.command = cmd;
    return item;
  endfunction

  task automatic send_item(nec_in_t item);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    sb.record_item(item);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_register(idx, value);
  endtask

  task automatic run_frame(logic [7:0] cmd, int unsigned noise_pct, bit retune);
    int unsigned slot;
    int unsigned retune_at;
    slot      = 0;
    retune_at = $urandom_range(1, 60);
    send_item(make_item(KindRequest, cmd));
    while (sb.busy()) begin
      if (retune && slot == retune_at) begin
        drain();
        write_reg(CfgIndexW'($urandom_range(0, 3)), CfgDataW'($urandom_range(0, 6)));
      end
      if ($urandom_range(0, 99) < noise_pct) begin
        send_item(make_item(KindRequest, 8'($urandom)));
      end else begin
        send_item(make_item(KindTick, 8'($urandom)));
      end
      slot++;
    end
  endtask

  task automatic random_config();
    logic [CfgIndexW-1:0] idx;
    logic [CfgDataW-1:0]  value;
    repeat ($urandom_range(1, 4)) begin
      idx = CfgIndexW'($urandom_range(0, 3));
      if (idx == RegLeaderMarkUnits || idx == RegLeaderSpaceUnits) begin
        if ($urandom_range(0, 7) == 0) value = CfgDataW'($urandom_range(0, 255));
        else value = CfgDataW'($urandom_range(0, 5));
      end else begin
        value = CfgDataW'($urandom_range(0, 255));
      end
      write_reg(idx, value);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
        $display("nec_ir_frame_transmitter_unit: mismatch");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned hold;
    wait (rst_ni === 1'b1);
    forever begin
      hold = pick_gap();
      @(negedge clk_i);
      out_stall_i <= (hold != 0);
      if (hold != 0) begin
        repeat (hold) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
      sb.compare_envelope(out_data_o);
    end
  end

  initial begin
    sb          = new();
    quiet       = 1'b0;
    items_sent  = 0;
    idle_cycles = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // A tick while idle, then a frame at the reset settings with two request
    // transactions that arrive while busy.
    send_item(make_item(KindTick, 8'hFF));
    send_item(make_item(KindRequest, 8'h00));
    send_item(make_item(KindRequest, 8'hFF));
    run_frame(8'h00, 0, 1'b0);

    // Register extremes, including zero lengths that must act as one unit.
    drain();
    write_reg(RegDeviceAddress, 8'hFF);
    write_reg(RegLeaderMarkUnits, 8'hFF);
    write_reg(RegLeaderSpaceUnits, 8'h00);
    write_reg(RegOneSpaceUnits, 8'hFF);
    run_frame(8'hFF, 0, 1'b0);

    drain();
    write_reg(RegDeviceAddress, 8'h5A);
    write_reg(RegLeaderMarkUnits, 8'h00);
    write_reg(RegLeaderSpaceUnits, 8'h1F);
    write_reg(RegOneSpaceUnits, 8'h00);
    run_frame(8'hA5, 0, 1'b0);

    // A register write in the middle of a frame takes effect at once.
    drain();
    write_reg(RegLeaderMarkUnits, 8'h03);
    write_reg(RegLeaderSpaceUnits, 8'h02);
    write_reg(RegOneSpaceUnits, 8'h05);
    run_frame(8'h3C, 5, 1'b1);

    while (items_sent < 1000) begin
      quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0) begin
        drain();
        random_config();
      end
      repeat ($urandom_range(0, 3)) send_item(make_item(KindTick, 8'($urandom)));
      run_frame(8'($urandom_range(0, 255)), $urandom_range(0, 8), $urandom_range(0, 3) == 0);
    end

    drain();
    repeat (4) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("nec_ir_frame_transmitter_unit: match");
    end else begin
      $display("nec_ir_frame_transmitter_unit: mismatch");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+design
design/necirtx_pkg.sv
design/nec_ir_frame_transmitter_unit.sv
design/necirtx_checker.sv
tb/testbench.sv
